@@ rtl/assert_macros.svh @@
// Assertion macros used by the framer RTL.
// Used by files that carry concurrent checks; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define MVTF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// condition must never be true outside reset
`define MVTF_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MVTF_ASSERT(lbl, clk, rstn, prop)
`define MVTF_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ rtl/mvtf_pkg.sv @@
// Package for the MCTP-over-PCIe-VDM transmit framer.
// Constants, controller states and the control/status structs; no dependencies.
`default_nettype none
package mvtf_pkg;

  // chunk size and derived widths
  localparam int MTU_BYTES = 64;
  localparam int FILL_W    = $clog2(MTU_BYTES + 1);
  localparam int DW_DEPTH  = (MTU_BYTES + 3) / 4;
  localparam int PIDX_W    = (DW_DEPTH > 1) ? $clog2(DW_DEPTH) : 1;

  // header constants
  localparam logic [7:0]  VDM_ROUTE_ID = 8'h72;
  localparam logic [7:0]  VDM_LEN_HI   = 8'h10;
  localparam logic [15:0] REQUESTER_ID = 16'h0015;
  localparam logic [7:0]  MCTP_CODE    = 8'h7f;
  localparam logic [15:0] VENDOR_ID    = 16'hB41A;
  localparam logic [7:0]  MCTP_VERSION = 8'h01;
  localparam logic [3:0]  MCTP_TO_LOW  = 4'h8;

  // register map
  localparam logic REG_TARGET_ID = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_RD,
    S_PAY
  } ctl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic load_hdr;
    logic rd;
    logic load_pay;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic flush;
    logic hdr_last;
    logic pay_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/mvtf_if.sv @@
// Stream interfaces of the framer: message bytes in, packet words out.
// Stand-alone; no package needed.
`default_nettype none
interface mvtf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mvtf_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] packet_word;
  logic        packet_end;
  modport source (output valid, output packet_word, output packet_end, input ready);
  modport sink (input valid, input packet_word, input packet_end, output ready);
endinterface
`default_nettype wire

@@ rtl/mctp_pcie_vdm_tx_framer.sv @@
// MCTP-over-PCIe-VDM transmit framer, top level: APB register, controller, datapath.
// Bytes are taken one per cycle while a chunk fills. On the last byte of a message or
// a full chunk, the packet of 4 header words plus N = ceil(len/4) payload words leaves
// (each payload word is read from memory, then loaded to the output register; a load
// waits while the output is held); no byte is taken meanwhile. Output is registered.
// Reset (rst_ni, async low) clears counters, sequence and target id; no memory sweep.
`default_nettype none
module mctp_pcie_vdm_tx_framer
  import mvtf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  mvtf_byte_if.sink   in_i,
  mvtf_word_if.source out_o,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_we;
  logic [15:0] target_id;

  // APB register decode
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_TARGET_ID);
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TARGET_ID) prdata = {16'h0000, target_id};
  end

  mvtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mvtf_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (in_i.data_byte),
    .last_byte_i   (in_i.last_byte),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (pwdata[15:0]),
    .target_id_o   (target_id),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .packet_word_o (out_o.packet_word),
    .packet_end_o  (out_o.packet_end)
  );

endmodule
`default_nettype wire

@@ rtl/mvtf_ctrl.sv @@
// Framer controller: collects bytes, then sequences header and payload words.
// Depends on mvtf_pkg for states and the command/status structs.
`default_nettype none
module mvtf_ctrl
  import mvtf_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.flush) state_d = S_HDR;
        end
      end
      S_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.load_hdr = 1'b1;
          if (sts_i.hdr_last) state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_PAY;
      end
      S_PAY: begin
        if (sts_i.out_free) begin
          cmd_o.load_pay = 1'b1;
          state_d        = sts_i.pay_last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mvtf_dpath.sv @@
// Framer datapath: chunk memory, counters, header build and output register.
// Depends on mvtf_pkg; assertions through assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mvtf_dpath
  import mvtf_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         last_byte_i,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  output logic [15:0] target_id_o,
  input  wire         out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] packet_word_o,
  output logic        packet_end_o
);

  logic [31:0]       chunk_q [DW_DEPTH];
  logic [31:0]       rdata_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [1:0]        seq_q, seq_d;
  logic              first_q, first_d;
  logic              last_q;
  logic [1:0]        hidx_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [15:0]       target_id_q;
  logic              out_valid_q;
  logic [31:0]       out_word_q;
  logic              out_end_q;

  logic [PIDX_W-1:0] waddr;
  logic [9:0]        dwords;
  logic [1:0]        pad;
  logic [FILL_W-1:0] nd_m1;
  logic [31:0]       hdr_word;
  logic [31:0]       pay_mask;
  logic              finish;

  assign waddr  = PIDX_W'(fill_q >> 2);
  assign dwords = 10'(({1'b0, fill_q} + (FILL_W + 1)'(3)) >> 2);
  assign pad    = 2'(3'd4 - {1'b0, fill_q[1:0]});
  assign nd_m1  = (fill_q - FILL_W'(1)) >> 2;
  assign finish = cmd_i.load_pay & sts_o.pay_last;

  // status to the controller
  assign sts_o.flush    = last_byte_i | (fill_q == FILL_W'(MTU_BYTES - 1));
  assign sts_o.hdr_last = (hidx_q == 2'd3);
  assign sts_o.pay_last = (FILL_W'(pidx_q) == nd_m1);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  // chunk memory: byte lane write, registered word read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) chunk_q[waddr][{fill_q[1:0], 3'b000} +: 8] <= data_byte_i;
    if (cmd_i.rd) rdata_q <= chunk_q[pidx_q];
  end

  // header words, first byte in the low lane
  always_comb begin
    case (hidx_q)
      2'd0: hdr_word = {dwords[7:0], VDM_LEN_HI | {6'd0, dwords[9:8]}, 8'h00, VDM_ROUTE_ID};
      2'd1: hdr_word = {MCTP_CODE, {2'b00, pad, 4'h0}, REQUESTER_ID[15:8],
                        REQUESTER_ID[7:0]};
      2'd2: hdr_word = {VENDOR_ID[15:8], VENDOR_ID[7:0], target_id_q[15:8], target_id_q[7:0]};
      default: hdr_word = {first_q, last_q, seq_q, MCTP_TO_LOW, 16'h0000, MCTP_VERSION};
    endcase
  end

  // zero the pad lanes of the final payload word
  always_comb begin
    pay_mask = 32'hffff_ffff;
    if (sts_o.pay_last) begin
      case (fill_q[1:0])
        2'd1:    pay_mask = 32'h0000_00ff;
        2'd2:    pay_mask = 32'h0000_ffff;
        2'd3:    pay_mask = 32'h00ff_ffff;
        default: pay_mask = 32'hffff_ffff;
      endcase
    end
  end

  // message state updates
  always_comb begin
    fill_d  = fill_q;
    seq_d   = seq_q;
    first_d = first_q;
    if (cmd_i.accept) fill_d = fill_q + FILL_W'(1);
    if (finish) begin
      fill_d  = '0;
      seq_d   = last_q ? 2'd0 : seq_q + 2'd1;
      first_d = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      seq_q       <= '0;
      first_q     <= 1'b1;
      last_q      <= 1'b0;
      hidx_q      <= '0;
      pidx_q      <= '0;
      target_id_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      seq_q   <= seq_d;
      first_q <= first_d;
      if (cfg_we_i) target_id_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        last_q <= last_byte_i;
        hidx_q <= '0;
        pidx_q <= '0;
      end
      if (cmd_i.load_hdr) hidx_q <= hidx_q + 2'd1;
      if (cmd_i.load_pay) pidx_q <= pidx_q + PIDX_W'(1);
      if (cmd_i.load_hdr | cmd_i.load_pay) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // output word register: header or payload words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hdr) begin
      out_word_q <= hdr_word;
      out_end_q  <= 1'b0;
    end else if (cmd_i.load_pay) begin
      out_word_q <= rdata_q & pay_mask;
      out_end_q  <= sts_o.pay_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packet_word_o = out_word_q;
  assign packet_end_o  = out_end_q;
  assign target_id_o   = target_id_q;

  `MVTF_ASSERT(a_fill_clear, clk_i, rst_ni, finish |=> fill_q == '0)
  `MVTF_ASSERT(a_fill_step, clk_i, rst_ni,
               cmd_i.accept && !sts_o.flush |=> fill_q == $past(fill_q) + FILL_W'(1))
  `MVTF_ASSERT(a_eom_resets, clk_i, rst_ni, finish && last_q |=> seq_q == 2'd0 && first_q)
  `MVTF_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FILL_W'(MTU_BYTES))

endmodule
`default_nettype wire
